// File: hw/rtl/kdtrq_pkg.sv
package kdtrq_pkg;

   localparam int MaxDepth  = 10;
   localparam int MaxPoints = 4096;
   localparam int MaxDims   = 4;
   localparam int NodeCount = 4095;
   localparam int NodeAw    = 12;
   localparam int IdAw      = 12;
   localparam int LvlW      = 4;

   typedef enum logic [1:0] {
      KIND_NODE  = 2'd0,
      KIND_ID    = 2'd1,
      KIND_START = 2'd2,
      KIND_NEXT  = 2'd3
   } kind_type;

   typedef enum logic [0:0] {
      CSR_DIMS  = 1'd0,
      CSR_DEPTH = 1'd1
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [11:0]        slot;
      logic               node_leaf;
      logic signed [31:0] node_split;
      logic [12:0]        node_first;
      logic [12:0]        node_end;
      logic [11:0]        point_ref;
      logic signed [31:0] centre_x;
      logic signed [31:0] centre_y;
      logic signed [31:0] centre_z;
      logic signed [31:0] centre_w;
      logic [30:0]        query_radius;
   } req_type;

   typedef struct packed {
      logic [11:0] found_id;
      logic        found;
   } rsp_type;

endpackage

// File: hw/rtl/kd_tree_radius_query.sv
// Channel | Direction | Handshake              | Word
// req     | in        | req_start & !req_busy  | req_word (req_type)
// rsp     | out       | rsp_strobe, one cycle  | rsp_word (rsp_type)
// csr     | in        | csr_valid & csr_ready  | csr_index, csr_data
//
// Write, start and idle next words answer in the cycle right after acceptance;
// busy drops in the cycle after the answer, so a new word cannot be taken
// until the last one is answered. For each node visited a next word reads node
// memory, then decides; it climbs one level per climb state while backtracking,
// then reads id memory, evaluates the id and answers.
// Reset is synchronous; node and id memories are not cleared.
// The receiver cannot stall: rsp_strobe lasts exactly one cycle.
module kd_tree_radius_query
   import kdtrq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   output logic        req_busy,
   input  req_type     req_word,
   output logic        rsp_strobe,
   output rsp_type     rsp_word,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_data
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_NRD   = 7'b0000010,
      ST_NEVAL = 7'b0000100,
      ST_IRD   = 7'b0001000,
      ST_IEVAL = 7'b0010000,
      ST_CLIMB = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   // memories
   logic [31:0] split_mem [NodeCount];
   logic        leaf_mem  [NodeCount];
   logic [12:0] first_mem [NodeCount];
   logic [12:0] end_mem   [NodeCount];
   logic [11:0] id_mem    [MaxPoints];

   logic [31:0] n_split_ff;
   logic        n_leaf_ff;
   logic [12:0] n_first_ff, n_end_ff;
   logic [11:0] id_rd_ff;

   state_type          state_ff, state_in;
   logic [2:0]         dims_ff;
   logic [3:0]         depth_ff;
   logic signed [31:0] centre_ff [MaxDims];
   logic [30:0]        radius_ff;
   logic [NodeAw-1:0]  cursor_ff, cursor_in;
   logic [LvlW-1:0]    level_ff, level_in;
   logic [MaxDepth-1:0] pend_ff, pend_in;
   logic [12:0]        offset_ff, offset_in;
   logic               finished_ff, finished_in;
   logic               hit_ff, hit_in;
   logic [11:0]        hid_ff, hid_in;
   logic [1:0]         kind_ff;
   logic [1:0]         ax;
   logic [2:0]         dims_eff;
   logic [3:0]         depth_eff;
   logic [13:0]        idx;

   logic accept;
   assign accept    = req_start && state_ff == ST_IDLE;
   assign req_busy  = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;

   always_comb begin
      dims_eff  = (dims_ff == 3'd0) ? 3'd1 : (dims_ff > 3'(MaxDims) ? 3'(MaxDims) : dims_ff);
      depth_eff = (depth_ff > 4'(MaxDepth)) ? 4'(MaxDepth) : depth_ff;
   end

   // split axis = level mod dims, taken fresh from the current config
   always_comb begin
      case (dims_eff)
         3'd2: ax = {1'b0, level_ff[0]};
         3'd3: begin
            if (level_ff inside {4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15}) ax = 2'd0;
            else if (level_ff inside {4'd1, 4'd4, 4'd7, 4'd10, 4'd13}) ax = 2'd1;
            else ax = 2'd2;
         end
         3'd4: ax = level_ff[1:0];
         default: ax = 2'd0;
      endcase
   end

   // memory writes and registered reads
   always_ff @(posedge clock) begin
      if (accept && req_word.kind == KIND_NODE && req_word.slot != 12'hFFF) begin
         split_mem[req_word.slot] <= req_word.node_split;
         leaf_mem[req_word.slot]  <= req_word.node_leaf;
         first_mem[req_word.slot] <= req_word.node_first;
         end_mem[req_word.slot]   <= req_word.node_end;
      end
      if (accept && req_word.kind == KIND_ID) begin
         id_mem[req_word.slot] <= req_word.point_ref;
      end
      if (cursor_ff != 12'hFFF) begin
         n_split_ff <= split_mem[cursor_ff];
         n_leaf_ff  <= leaf_mem[cursor_ff];
         n_first_ff <= first_mem[cursor_ff];
         n_end_ff   <= end_mem[cursor_ff];
      end else begin
         n_split_ff <= '0;
         n_leaf_ff  <= 1'b1;
         n_first_ff <= '0;
         n_end_ff   <= '0;
      end
      id_rd_ff <= id_mem[idx[11:0]];
   end

   // one spare bit so a rewritten leaf with a high first slot cannot wrap
   assign idx = {1'b0, n_first_ff} + {1'b0, offset_ff};

   // compare against the box on the current axis
   logic signed [33:0] c_ext, lo, hi, s_ext;
   logic is_leaf, in_store;
   always_comb begin
      c_ext    = 34'(centre_ff[ax]);
      lo       = c_ext - 34'({3'b0, radius_ff});
      hi       = c_ext + 34'({3'b0, radius_ff});
      s_ext    = 34'($signed(n_split_ff));
      in_store = cursor_ff != 12'hFFF;
      is_leaf  = !in_store || n_leaf_ff || level_ff >= depth_eff;
   end

   always_comb begin
      state_in    = state_ff;
      cursor_in   = cursor_ff;
      level_in    = level_ff;
      pend_in     = pend_ff;
      offset_in   = offset_ff;
      finished_in = finished_ff;
      hit_in      = hit_ff;
      hid_in      = hid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hit_in = 1'b0;
               hid_in = '0;
               if (req_word.kind == KIND_START) begin
                  cursor_in = '0; level_in = '0; pend_in = '0;
                  offset_in = '0; finished_in = 1'b0;
               end
               if (req_word.kind == KIND_NEXT && !finished_ff) state_in = ST_NRD;
               else state_in = ST_RESP;
            end
         end
         ST_NRD: state_in = ST_NEVAL;
         ST_NEVAL: begin
            if (!is_leaf) begin
               if (s_ext > lo) begin
                  pend_in[level_ff] = s_ext < hi;
                  cursor_in = {cursor_ff[NodeAw-2:0], 1'b1};
               end else begin
                  pend_in[level_ff] = 1'b0;
                  cursor_in = {cursor_ff[NodeAw-2:0], 1'b0} + 12'd2;
               end
               level_in  = level_ff + 4'd1;
               offset_in = '0;
               state_in  = ST_NRD;
            end else if (in_store && idx < {1'b0, n_end_ff} && idx[13:12] == 2'b00) begin
               state_in = ST_IRD;
            end else begin
               state_in = ST_CLIMB;
            end
         end
         ST_IRD: state_in = ST_IEVAL;
         ST_IEVAL: begin
            hit_in    = 1'b1;
            hid_in    = id_rd_ff;
            offset_in = offset_ff + 13'd1;
            state_in  = ST_RESP;
         end
         ST_CLIMB: begin
            // one level per cycle
            if (level_ff == '0) begin
               finished_in = 1'b1;
               state_in    = ST_RESP;
            end else begin
               level_in  = level_ff - 4'd1;
               cursor_in = (cursor_ff - 12'd1) >> 1;
               if (pend_ff[level_ff - 4'd1]) begin
                  pend_in[level_ff - 4'd1] = 1'b0;
                  cursor_in = {cursor_in[NodeAw-2:0], 1'b0} + 12'd2;
                  level_in  = level_ff;
                  offset_in = '0;
                  state_in  = ST_NRD;
               end
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         dims_ff     <= 3'd3;
         depth_ff    <= 4'd10;
         radius_ff   <= '0;
         cursor_ff   <= '0;
         level_ff    <= '0;
         pend_ff     <= '0;
         offset_ff   <= '0;
         finished_ff <= 1'b1;
         hit_ff      <= 1'b0;
         hid_ff      <= '0;
         kind_ff     <= '0;
         for (int i = 0; i < MaxDims; i++) centre_ff[i] <= '0;
      end else begin
         state_ff    <= state_in;
         cursor_ff   <= cursor_in;
         level_ff    <= level_in;
         pend_ff     <= pend_in;
         offset_ff   <= offset_in;
         finished_ff <= finished_in;
         hit_ff      <= hit_in;
         hid_ff      <= hid_in;
         if (accept) kind_ff <= req_word.kind;
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_DIMS:  dims_ff  <= csr_data[2:0];
               CSR_DEPTH: depth_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept && req_word.kind == KIND_START) begin
            centre_ff[0] <= req_word.centre_x;
            centre_ff[1] <= req_word.centre_y;
            centre_ff[2] <= req_word.centre_z;
            centre_ff[3] <= req_word.centre_w;
            radius_ff    <= req_word.query_radius;
         end
      end
   end

   assign rsp_strobe        = state_ff == ST_RESP;
   assign rsp_word.found    = hit_ff;
   assign rsp_word.found_id = hit_ff ? hid_ff : '0;

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_hit_next: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.found |-> kind_ff == KIND_NEXT)
      else $error("hit on non-next word");
   a_level: assert property (@(posedge clock) disable iff (reset)
      level_ff <= 4'(MaxDepth))
      else $error("level overflow");
   a_done: assert property (@(posedge clock) disable iff (reset)
      finished_ff && state_ff == ST_RESP |-> !hit_ff || kind_ff == KIND_NEXT)
      else $error("finished hit");

endmodule

// File: tb/tb_kd_tree_radius_query.sv
`timescale 1ns / 100ps

module tb_kd_tree_radius_query;
   import kdtrq_pkg::*;

   localparam int  SettleCycles = 40;
   localparam int  ItemTarget   = 1750;
   localparam longint CycleLimit = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_start = 1'b0;
   logic        req_busy;
   req_type     req_word = '0;
   logic        rsp_strobe;
   rsp_type     rsp_word;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = CSR_DIMS;
   logic [3:0]  csr_data = '0;

   kd_tree_radius_query u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_start  (req_start),
      .req_busy   (req_busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // words waiting to be driven, and answers the walk predicts
   req_type pending_words[$];
   rsp_type expected_hits[$];

   int     fail_count = 0;
   int     words_sent = 0;
   int     answers_seen = 0;
   int     hits_seen = 0;
   int     queries_issued = 0;
   int     phases_run = 0;
   longint cycle_count = 0;

   // ---------------------------------------------------------------
   // Shadow of the block: node/id memories, query registers, config
   // ---------------------------------------------------------------
   logic [31:0]        sh_split[NodeCount];
   bit                 sh_leaf[NodeCount];
   logic [12:0]        sh_first[NodeCount];
   logic [12:0]        sh_end[NodeCount];
   logic [11:0]        sh_id[MaxPoints];
   logic signed [31:0] sh_centre[4];
   logic [30:0]        sh_radius;
   int unsigned        sh_node, sh_level, sh_offset;
   logic [15:0]        sh_pending;
   bit                 sh_done;
   int unsigned        sh_dims, sh_depth;

   // one next word: descend/backtrack until a candidate id or the end
   function automatic bit walk_tree(output logic [11:0] hit);
      int unsigned lim, nd, idx, ax;
      bit          in_mem, as_leaf;
      longint      c, s, r;
      hit = '0;
      lim = (sh_depth > MaxDepth) ? MaxDepth : sh_depth;
      nd  = (sh_dims == 0) ? 1 : ((sh_dims > MaxDims) ? MaxDims : sh_dims);
      forever begin
         in_mem  = sh_node < NodeCount;
         as_leaf = !in_mem || sh_leaf[sh_node] || sh_level >= lim;
         if (!as_leaf) begin
            ax = sh_level % nd;
            c  = longint'(sh_centre[ax]);
            s  = longint'($signed(sh_split[sh_node]));
            r  = longint'({1'b0, sh_radius});
            if (s > c - r) begin
               sh_pending[sh_level] = (s < c + r);
               sh_node = sh_node * 2 + 1;
            end else begin
               sh_pending[sh_level] = 1'b0;
               sh_node = sh_node * 2 + 2;
            end
            sh_level++;
            sh_offset = 0;
            continue;
         end
         if (in_mem) begin
            idx = sh_first[sh_node] + sh_offset;
            if (idx < sh_end[sh_node] && idx < MaxPoints) begin
               hit = sh_id[idx];
               sh_offset++;
               return 1'b1;
            end
         end
         // leaf used up: climb to nearest pending right branch
         forever begin
            if (sh_level == 0) begin
               sh_done = 1'b1;
               return 1'b0;
            end
            sh_level--;
            sh_node = (sh_node - 1) / 2;
            if (sh_pending[sh_level]) begin
               sh_pending[sh_level] = 1'b0;
               sh_node = sh_node * 2 + 2;
               sh_level++;
               sh_offset = 0;
               break;
            end
         end
      end
   endfunction

   function automatic rsp_type predict_answer(req_type w);
      rsp_type     a;
      logic [11:0] hit;
      a = '0;
      case (w.kind)
         KIND_NODE: begin
            if (w.slot < NodeCount) begin
               sh_leaf[w.slot]  = w.node_leaf;
               sh_split[w.slot] = w.node_split;
               sh_first[w.slot] = w.node_first;
               sh_end[w.slot]   = w.node_end;
            end
         end
         KIND_ID: sh_id[w.slot] = w.point_ref;
         KIND_START: begin
            sh_centre[0] = w.centre_x;
            sh_centre[1] = w.centre_y;
            sh_centre[2] = w.centre_z;
            sh_centre[3] = w.centre_w;
            sh_radius  = w.query_radius;
            sh_node    = 0;
            sh_level   = 0;
            sh_pending = '0;
            sh_offset  = 0;
            sh_done    = 1'b0;
         end
         default: begin
            if (!sh_done && walk_tree(hit)) begin
               a.found    = 1'b1;
               a.found_id = hit;
            end
         end
      endcase
      return a;
   endfunction

   initial begin
      for (int i = 0; i < NodeCount; i++) begin
         sh_split[i] = '0; sh_leaf[i] = 1'b0; sh_first[i] = '0; sh_end[i] = '0;
      end
      for (int i = 0; i < MaxPoints; i++) sh_id[i] = '0;
      for (int i = 0; i < 4; i++) sh_centre[i] = '0;
      sh_radius = '0; sh_node = 0; sh_level = 0; sh_offset = 0;
      sh_pending = '0; sh_done = 1'b1;
      sh_dims = 3; sh_depth = 10;
   end

   // ---------------------------------------------------------------
   // Driver: bursts of words with random gaps, changes on falling edge
   // ---------------------------------------------------------------
   bit taken;          // word accepted at last rising edge
   int gap_left = 0;
   int burst_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_start <= 1'b0;
      end else if (req_start && !taken) begin
         // hold current word until accepted
      end else if (gap_left > 0) begin
         gap_left--;
         req_start <= 1'b0;
      end else if (pending_words.size() > 0) begin
         req_word  <= pending_words.pop_front();
         req_start <= 1'b1;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 30);
            // some bursts run back to back with no gap at all
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
      end else begin
         req_start <= 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Monitor: predict on acceptance, check each strobed answer
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      taken <= !reset && req_start && !req_busy;
      if (!reset) begin
         if (req_start && !req_busy) begin
            expected_hits.push_back(predict_answer(req_word));
            words_sent++;
         end
         if (rsp_strobe) begin
            answers_seen++;
            if (expected_hits.size() == 0) begin
               $error("answer with nothing expected: found_id %0d found %0d",
                      rsp_word.found_id, rsp_word.found);
               fail_count++;
            end else begin
               rsp_type e;
               e = expected_hits.pop_front();
               if (rsp_word.found_id !== e.found_id) begin
                  $error("found_id: expected %0d, actual %0d", e.found_id, rsp_word.found_id);
                  fail_count++;
               end
               if (rsp_word.found !== e.found) begin
                  $error("found: expected %0d, actual %0d", e.found, rsp_word.found);
                  fail_count++;
               end
               if (e.found) hits_seen++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   int tree_lim;
   int tree_nodes;
   int inner_nodes[$];

   function automatic req_type noise_word(logic [1:0] k);
      logic [255:0] b;
      req_type      w;
      b = {$urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
      w = b[$bits(req_type)-1:0];
      w.kind = k;
      return w;
   endfunction

   // Q16.16 near the origin most of the time, full range now and then
   function automatic logic [31:0] coord();
      if ($urandom_range(0, 15) == 0) return $urandom;
      return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
   endfunction

   // leaf id range that only touches written id slots
   function automatic void leaf_range(inout req_type w);
      int f;
      case ($urandom_range(0, 9))
         0: begin  // empty
            f = $urandom_range(0, 8191);
            w.node_first = 13'(f);
            w.node_end   = 13'($urandom_range(0, f));
         end
         1: begin  // runs into the top of the id list
            w.node_first = 13'($urandom_range(MaxPoints - 2, MaxPoints - 1));
            w.node_end   = 13'($urandom_range(MaxPoints - 2, MaxPoints + 100));
         end
         2: begin  // starts beyond the id list
            w.node_first = 13'($urandom_range(MaxPoints, 8191));
            w.node_end   = 13'($urandom_range(0, 8191));
         end
         default: begin
            f = $urandom_range(0, 60);
            w.node_first = 13'(f);
            w.node_end   = 13'(f + $urandom_range(0, 4));
         end
      endcase
   endfunction

   task automatic push(req_type w);
      pending_words.push_back(w);
   endtask

   task automatic build_node(int n, int lvl);
      req_type w;
      bit      make_leaf;
      w = noise_word(KIND_NODE);
      w.slot = 12'(n);
      w.node_split = coord();
      tree_nodes++;
      make_leaf = (lvl >= tree_lim) || tree_nodes > 60 ||
                  (lvl > 0 && $urandom_range(0, 99) < 20 + lvl * 8);
      if (make_leaf) begin
         // at the depth limit the flag does not matter
         w.node_leaf = (lvl >= tree_lim) ? 1'($urandom) : 1'b1;
         leaf_range(w);
         push(w);
      end else begin
         w.node_leaf = 1'b0;
         push(w);
         inner_nodes.push_back(n);
         build_node(2 * n + 1, lvl + 1);
         build_node(2 * n + 2, lvl + 1);
      end
   endtask

   task automatic start_query();
      req_type w;
      w = noise_word(KIND_START);
      w.centre_x = coord();
      w.centre_y = coord();
      w.centre_z = coord();
      w.centre_w = coord();
      case ($urandom_range(0, 9))
         0: w.query_radius = '0;
         1: w.query_radius = '1;
         2: w.query_radius = 31'($urandom);
         default: w.query_radius = 31'($urandom_range(0, 32'h0003_0000));
      endcase
      push(w);
      queries_issued++;
   endtask

   task automatic wait_idle();
      wait (pending_words.size() == 0 && !req_start && expected_hits.size() == 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [3:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_DIMS) sh_dims = val[2:0];
      else sh_depth = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      req_type w;
      int      n_next, target, setup;
      int      dims_plan[8]  = '{1, 4, 0, 7, 3, 2, 5, 1};
      int      depth_plan[8] = '{0, 10, 15, 3, 5, 7, 12, 1};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part, reset config (3 axes, depth 10) ---
      push(noise_word(KIND_NEXT));               // next with no query active
      for (int i = 0; i < 8; i++) begin
         w = noise_word(KIND_ID); w.slot = 12'(i); push(w);
      end
      w = noise_word(KIND_ID); w.slot = 12'(MaxPoints - 2); w.point_ref = '1; push(w);
      w = noise_word(KIND_ID); w.slot = 12'(MaxPoints - 1); w.point_ref = '0; push(w);
      w = noise_word(KIND_NODE); w.slot = 12'(NodeCount); push(w);   // past node memory
      w = noise_word(KIND_NODE); w.slot = '0; w.node_leaf = 1'b0; w.node_split = '0; push(w);
      w = noise_word(KIND_NODE); w.slot = 12'd1; w.node_leaf = 1'b1;
      w.node_first = 13'd0; w.node_end = 13'd3; push(w);
      w = noise_word(KIND_NODE); w.slot = 12'd2; w.node_leaf = 1'b1;   // clipped at id list end
      w.node_first = 13'(MaxPoints - 2); w.node_end = 13'h1FFF; push(w);
      w = noise_word(KIND_START); w.centre_x = '0; w.query_radius = 31'h0001_0000; push(w);
      repeat (7) push(noise_word(KIND_NEXT));
      w = noise_word(KIND_START); w.centre_x = 32'sh7FFF_FFFF; w.query_radius = '0; push(w);
      repeat (2) push(noise_word(KIND_NEXT));
      w = noise_word(KIND_START); w.centre_x = 32'sh8000_0000; w.query_radius = '1; push(w);
      w = noise_word(KIND_NODE); w.slot = 12'd1; w.node_leaf = 1'b1;   // empty leaf mid-query
      w.node_first = 13'd5; w.node_end = 13'd5; push(w);
      repeat (4) push(noise_word(KIND_NEXT));

      // --- random phases, each under its own config ---
      for (int ph = 0; ph < 8; ph++) begin
         wait_idle();
         write_csr(CSR_DIMS, 4'(dims_plan[ph]));
         write_csr(CSR_DEPTH, 4'(depth_plan[ph]));
         phases_run++;
         tree_lim = (depth_plan[ph] > MaxDepth) ? MaxDepth : depth_plan[ph];
         // id slots that leaves point at, written once
         if (ph == 0) begin
            for (int i = 0; i < 64; i++) begin
               w = noise_word(KIND_ID); w.slot = 12'(i); push(w);
            end
         end
         tree_nodes = 0;
         inner_nodes.delete();
         build_node(0, 0);
         setup  = pending_words.size();
         target = setup + ((ItemTarget / 8 > setup + 60) ? ItemTarget / 8 - setup : 60);
         while (pending_words.size() < target) begin
            start_query();
            n_next = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                 : $urandom_range(1, 30);
            for (int k = 0; k < n_next; k++) begin
               case ($urandom_range(0, 19))
                  0: begin  // leaf dropped anywhere, even mid-query
                     w = noise_word(KIND_NODE); w.node_leaf = 1'b1; leaf_range(w); push(w);
                  end
                  1: begin  // new split on an inner node of this tree
                     if (inner_nodes.size() > 0) begin
                        w = noise_word(KIND_NODE);
                        w.slot = 12'(inner_nodes[$urandom_range(0, inner_nodes.size() - 1)]);
                        w.node_leaf = 1'b0; w.node_split = coord(); push(w);
                     end
                  end
                  2: push(noise_word(KIND_ID));
                  default: ;
               endcase
               push(noise_word(KIND_NEXT));
            end
         end
      end

      wait (pending_words.size() == 0 && !req_start && expected_hits.size() == 0);
      repeat (SettleCycles) @(posedge clock);
      $display("%0d words in %0d config phases, %0d queries, %0d answers with %0d ids",
               words_sent, phases_run, queries_issued, answers_seen, hits_seen);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
